// ----- rtl/core/ptts_pkg.sv -----
package ptts_pkg;

  localparam int DATA_W      = 8;
  // Fire rows reported per tick; further firings still clear their counters.
  localparam int MAX_RESULTS = 8;
  localparam int FB_IDX_W    = $clog2(MAX_RESULTS);
  localparam int FB_CNT_W    = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_MODIFY = 2'd2,
    REQ_TICK   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] handle;
    logic [DATA_W-1:0] period;
    logic [DATA_W-1:0] prio;
    logic [DATA_W-1:0] counter;
  } entry_t;

  typedef struct packed {
    logic              ins;
    logic [DATA_W-1:0] prio;
    logic [DATA_W-1:0] handle;
  } fire_ins_t;

endpackage

// ----- rtl/core/periodic_task_table_scheduler.sv -----
// Periodic task table scheduler. Holds up to TABLE_DEPTH tasks (handle,
// interval, priority, tick counter) in a single-port-read table memory and
// serves one request at a time on the in_ stream. Create appends a task
// (status table full when all entries are used), delete removes the first
// matching handle and shifts later entries down, modify rewrites interval and
// priority of the first match; these return one beat with status. A tick
// advances every task of nonzero priority, clears and reports those whose
// counter reaches the interval, in ascending priority and table order, one
// beat per firing (at most eight reported), tlast on the final beat; a tick
// that fires nothing returns one beat with tuser low. The table memory
// returns one entry per cycle from a registered read, and output
// back-pressure holds the block in its response and emit states.
module periodic_task_table_scheduler
  import ptts_pkg::*;
#(
  parameter int TABLE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // task_handle, period_ticks, task_priority
  input  logic [1:0]  in_tuser,   // req_type

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status, fired_handle, zero pad
  output logic [0:0]  out_tuser,  // fired
  output logic        out_tlast
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FIND,
    S_SHIFT,
    S_RESP,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  req_t                req_r, req_nxt;
  logic [DATA_W-1:0]   hnd_r, hnd_nxt;
  logic [DATA_W-1:0]   per_r, per_nxt;
  logic [DATA_W-1:0]   pri_r, pri_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       rptr_r, rptr_nxt;
  logic                pv_r, pv_nxt;
  logic [AW-1:0]       pidx_r, pidx_nxt;
  status_t             status_r, status_nxt;
  logic [FB_CNT_W-1:0] ems_r, ems_nxt;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic                out_fired_r, out_fired_nxt;
  logic [DATA_W-1:0]   out_hnd_r, out_hnd_nxt;
  logic                out_last_r, out_last_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_wa;
  entry_t              ram_wd;
  logic                ram_re;
  entry_t              ram_rd;

  fire_ins_t           fb_fire;
  logic                fb_clr;
  logic [FB_CNT_W-1:0] fb_fill;
  logic [DATA_W-1:0]   fb_handle;

  logic                in_fire;
  logic                out_free;
  logic                issue;
  logic [DATA_W-1:0]   inc_cnt;
  logic                due;
  logic                emit_last;

  ptts_table_ram #(
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_wa),
    .wr_data(ram_wd),
    .rd_en  (ram_re),
    .rd_addr(rptr_r[AW-1:0]),
    .rd_data(ram_rd)
  );

  ptts_fire_buf u_fire_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (fb_clr),
    .fire     (fb_fire),
    .rd_idx   (ems_r[FB_IDX_W-1:0]),
    .fill     (fb_fill),
    .rd_handle(fb_handle)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;

  // walk the table one entry a cycle while a scan state is active
  assign issue = ((state_r == S_SCAN) || (state_r == S_FIND) || (state_r == S_SHIFT))
                 && (rptr_r < cnt_r);
  assign ram_re = issue;

  assign inc_cnt   = ram_rd.counter + DATA_W'(1);
  assign due       = (inc_cnt >= ram_rd.period);
  assign emit_last = ((ems_r + FB_CNT_W'(1)) == fb_fill);

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    hnd_nxt        = hnd_r;
    per_nxt        = per_r;
    pri_nxt        = pri_r;
    cnt_nxt        = cnt_r;
    rptr_nxt       = rptr_r;
    pv_nxt         = 1'b0;
    pidx_nxt       = pidx_r;
    status_nxt     = status_r;
    ems_nxt        = ems_r;

    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_fired_nxt  = out_fired_r;
    out_hnd_nxt    = out_hnd_r;
    out_last_nxt   = out_last_r;

    ram_we         = 1'b0;
    ram_wa         = pidx_r;
    ram_wd         = ram_rd;
    fb_clr         = 1'b0;
    fb_fire        = '0;

    if (issue) begin
      pv_nxt   = 1'b1;
      pidx_nxt = rptr_r[AW-1:0];
      rptr_nxt = rptr_r + CW'(1);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_nxt  = req_t'(in_tuser);
          hnd_nxt  = in_tdata[7:0];
          per_nxt  = in_tdata[15:8];
          pri_nxt  = in_tdata[23:16];
          rptr_nxt = '0;
          unique case (req_t'(in_tuser))
            REQ_CREATE: begin
              if (cnt_r == CW'(TABLE_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we         = 1'b1;
                ram_wa         = cnt_r[AW-1:0];
                ram_wd.handle  = in_tdata[7:0];
                ram_wd.period  = in_tdata[15:8];
                ram_wd.prio    = in_tdata[23:16];
                ram_wd.counter = '0;
                cnt_nxt        = cnt_r + CW'(1);
                status_nxt     = ST_OK;
              end
              state_nxt = S_RESP;
            end
            REQ_DELETE, REQ_MODIFY: begin
              state_nxt = S_FIND;
            end
            REQ_TICK: begin
              fb_clr    = 1'b1;
              state_nxt = S_SCAN;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // advance, and clear on reaching the interval; write back in place
        if (pv_r && (ram_rd.prio != '0)) begin
          ram_we         = 1'b1;
          ram_wa         = pidx_r;
          ram_wd.counter = due ? '0 : inc_cnt;
          fb_fire.ins    = due;
          fb_fire.prio   = ram_rd.prio;
          fb_fire.handle = ram_rd.handle;
        end
        if (!pv_r && !issue) begin
          ems_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end

      S_FIND: begin
        if (pv_r && (ram_rd.handle == hnd_r)) begin
          if (req_r == REQ_MODIFY) begin
            ram_we        = 1'b1;
            ram_wa        = pidx_r;
            ram_wd.period = per_r;
            ram_wd.prio   = pri_r;
            status_nxt    = ST_OK;
            state_nxt     = S_RESP;
          end else begin
            // start the shift at the entry after the match
            pv_nxt    = 1'b0;
            rptr_nxt  = CW'(pidx_r) + CW'(1);
            state_nxt = S_SHIFT;
          end
        end else if (!pv_r && !issue) begin
          status_nxt = ST_MISSING;
          state_nxt  = S_RESP;
        end
      end

      S_SHIFT: begin
        // move each later entry down by one slot
        if (pv_r) begin
          ram_we = 1'b1;
          ram_wa = pidx_r - AW'(1);
        end
        if (!pv_r && !issue) begin
          cnt_nxt    = cnt_r - CW'(1);
          status_nxt = ST_OK;
          state_nxt  = S_RESP;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_fired_nxt  = 1'b0;
          out_hnd_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          if (fb_fill == '0) begin
            out_fired_nxt = 1'b0;
            out_hnd_nxt   = '0;
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            out_fired_nxt = 1'b1;
            out_hnd_nxt   = fb_handle;
            out_last_nxt  = emit_last;
            ems_nxt       = ems_r + FB_CNT_W'(1);
            if (emit_last) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    hnd_r        <= hnd_nxt;
    per_r        <= per_nxt;
    pri_r        <= pri_nxt;
    rptr_r       <= rptr_nxt;
    pidx_r       <= pidx_nxt;
    status_r     <= status_nxt;
    ems_r        <= ems_nxt;
    out_status_r <= out_status_nxt;
    out_fired_r  <= out_fired_nxt;
    out_hnd_r    <= out_hnd_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_hnd_r, out_status_r};
  assign out_tuser  = out_fired_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/core/ptts_table_ram.sv -----
module ptts_table_ram
  import ptts_pkg::*;
#(
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/ptts_fire_buf.sv -----
module ptts_fire_buf
  import ptts_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clr,
  input  fire_ins_t           fire,
  input  logic [FB_IDX_W-1:0] rd_idx,
  output logic [FB_CNT_W-1:0] fill,
  output logic [DATA_W-1:0]   rd_handle
);

  // Rows kept sorted by priority; arrivals come in table order, so a new row
  // goes behind every row of equal or lower priority value.
  logic [DATA_W-1:0]   pri_r [MAX_RESULTS];
  logic [DATA_W-1:0]   hnd_r [MAX_RESULTS];
  logic [FB_CNT_W-1:0] fill_r;
  logic [FB_CNT_W-1:0] pos;
  logic                take;

  always_comb begin
    pos = '0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if ((FB_CNT_W'(k) < fill_r) && (pri_r[k] <= fire.prio)) begin
        pos = pos + FB_CNT_W'(1);
      end
    end
    take = fire.ins && (pos != FB_CNT_W'(MAX_RESULTS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (clr) begin
      fill_r <= '0;
    end else if (take && (fill_r != FB_CNT_W'(MAX_RESULTS))) begin
      fill_r <= fill_r + FB_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
        if (FB_CNT_W'(k) == pos) begin
          pri_r[k] <= fire.prio;
          hnd_r[k] <= fire.handle;
        end
      end
      // shift the tail down one slot, dropping the row pushed off the end
      for (int k = 1; k < MAX_RESULTS; k++) begin
        if (FB_CNT_W'(k) > pos) begin
          pri_r[k] <= pri_r[k-1];
          hnd_r[k] <= hnd_r[k-1];
        end
      end
    end
  end

  assign fill      = fill_r;
  assign rd_handle = hnd_r[rd_idx];

endmodule

// ----- tb/ptts_result_check.sv -----
module ptts_result_check
  import ptts_pkg::*;
#(
  parameter int TABLE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // task_handle, period_ticks, task_priority
  input  logic [1:0]  in_tuser,   // req_type
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // status, fired_handle, zero pad
  input  logic [0:0]  out_tuser,  // fired
  input  logic        out_tlast,
  output int          fail_count,
  output int          rows_waiting
);

  typedef struct packed {
    status_t    status;
    logic       fired;
    logic [7:0] handle;
    logic       last;
  } sched_row_t;

  // Shadow copy of the task table
  logic [7:0] tbl_handle [TABLE_DEPTH];
  logic [7:0] tbl_period [TABLE_DEPTH];
  logic [7:0] tbl_prio   [TABLE_DEPTH];
  logic [7:0] tbl_ticks  [TABLE_DEPTH];
  int         tbl_used;

  sched_row_t due_rows[$];
  int         errors = 0;

  task automatic push_row(input status_t st, input logic fr, input logic [7:0] h,
                          input logic lst);
    sched_row_t row;
    row.status = st;
    row.fired  = fr;
    row.handle = h;
    row.last   = lst;
    due_rows.push_back(row);
  endtask

  task automatic apply_to_table(input req_t req, input logic [7:0] h,
                                input logic [7:0] per, input logic [7:0] pri);
    int idx;
    int n;
    int p;
    int j;
    logic [7:0] fired_list [MAX_RESULTS];
    idx = -1;
    for (j = 0; j < tbl_used; j++) begin
      if (idx < 0 && tbl_handle[j] == h) idx = j;
    end
    case (req)
      REQ_CREATE: begin
        if (tbl_used >= TABLE_DEPTH) begin
          push_row(ST_FULL, 1'b0, 8'd0, 1'b1);
        end else begin
          tbl_handle[tbl_used] = h;
          tbl_period[tbl_used] = per;
          tbl_prio[tbl_used]   = pri;
          tbl_ticks[tbl_used]  = 8'd0;
          tbl_used++;
          push_row(ST_OK, 1'b0, 8'd0, 1'b1);
        end
      end
      REQ_DELETE: begin
        if (idx < 0) begin
          push_row(ST_MISSING, 1'b0, 8'd0, 1'b1);
        end else begin
          for (j = idx; j < tbl_used - 1; j++) begin
            tbl_handle[j] = tbl_handle[j+1];
            tbl_period[j] = tbl_period[j+1];
            tbl_prio[j]   = tbl_prio[j+1];
            tbl_ticks[j]  = tbl_ticks[j+1];
          end
          tbl_used--;
          push_row(ST_OK, 1'b0, 8'd0, 1'b1);
        end
      end
      REQ_MODIFY: begin
        if (idx < 0) begin
          push_row(ST_MISSING, 1'b0, 8'd0, 1'b1);
        end else begin
          tbl_period[idx] = per;
          tbl_prio[idx]   = pri;
          push_row(ST_OK, 1'b0, 8'd0, 1'b1);
        end
      end
      default: begin
        // tick: priority 1 first, table order within a priority; 0 is skipped
        n = 0;
        for (p = 1; p <= 255; p++) begin
          for (j = 0; j < tbl_used; j++) begin
            if (tbl_prio[j] == p) begin
              tbl_ticks[j] = tbl_ticks[j] + 8'd1;
              if (tbl_ticks[j] >= tbl_period[j]) begin
                tbl_ticks[j] = 8'd0;
                if (n < MAX_RESULTS) begin
                  fired_list[n] = tbl_handle[j];
                  n++;
                end
              end
            end
          end
        end
        if (n == 0) begin
          push_row(ST_OK, 1'b0, 8'd0, 1'b1);
        end else begin
          for (j = 0; j < n; j++) push_row(ST_OK, 1'b1, fired_list[j], j == n - 1);
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    sched_row_t want;
    if (!rst_n) begin
      tbl_used = 0;
      due_rows.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_rows.size() == 0) begin
          $error("result beat with nothing expected: tdata=%h tuser=%b tlast=%b",
                 out_tdata, out_tuser, out_tlast);
          errors++;
        end else begin
          want = due_rows.pop_front();
          check_field("status", 32'(want.status), 32'(out_tdata[1:0]));
          check_field("fired", 32'(want.fired), 32'(out_tuser[0]));
          check_field("fired_handle", 32'(want.handle), 32'(out_tdata[9:2]));
          check_field("last", 32'(want.last), 32'(out_tlast));
          check_field("pad", 32'd0, 32'(out_tdata[15:10]));
        end
      end
      if (in_tvalid && in_tready) begin
        apply_to_table(req_t'(in_tuser), in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]);
      end
    end
    fail_count   <= errors;
    rows_waiting <= due_rows.size();
  end

endmodule

// ----- tb/tb_periodic_task_table_scheduler.sv -----
module tb_periodic_task_table_scheduler;
  import ptts_pkg::*;

  localparam int DEPTH        = 8;
  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_CYCLES  = 300;   // one long receiver hold-off
  localparam int HOLD_AT      = 900;   // receiver cycles before that hold-off
  localparam int IDLE_LIMIT   = 3000;  // cycles without any beat before giving up
  localparam int DRAIN_CYCLES = 40;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // task_handle, period_ticks, task_priority
  logic [1:0]  in_tuser;   // req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // status, fired_handle, zero pad
  logic [0:0]  out_tuser;  // fired
  logic        out_tlast;
  int          fail_count;
  int          rows_waiting;
  int          idle_cycles;

  periodic_task_table_scheduler #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  ptts_result_check #(
    .TABLE_DEPTH(DEPTH)
  ) result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .rows_waiting(rows_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one request beat from the falling edge and hold it until accepted.
  task automatic send_req(input req_t req, input logic [7:0] h, input logic [7:0] per,
                          input logic [7:0] pri);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {pri, per, h};
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid so the sender pauses.
  task automatic pause_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  // Drop valid and hold until every predicted result beat has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (rows_waiting != 0) @(negedge clk);
  endtask

  // Receiver: stretches of always-ready, coin-flip and mostly-stalled ready,
  // plus one long hold-off so the block backs up into its input.
  initial begin
    int mode;
    int len;
    int cycles;
    bit held;
    out_tready = 1'b0;
    cycles     = 0;
    held       = 1'b0;
    wait (rst_n);
    forever begin
      if (!held && cycles >= HOLD_AT) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
        cycles += HOLD_CYCLES;
      end
      mode = $urandom_range(0, 2);
      len  = $urandom_range(16, 64);
      repeat (len) begin
        @(negedge clk);
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
        cycles++;
      end
    end
  end

  // Watchdog: count cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int sent;
    int burst;
    int gap;
    int r;
    int k;
    int w_create;
    int w_delete;
    int w_modify;
    req_t req;
    logic [7:0] h;
    logic [7:0] per;
    logic [7:0] pri;
    logic [7:0] handle_pool [6];

    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    rst_n       = 1'b0;
    for (k = 0; k < 6; k++) handle_pool[k] = 8'($urandom_range(0, 255));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty table: tick fires nothing, delete and modify find nothing.
    send_req(REQ_TICK,   8'h00, 8'h00, 8'h00);
    send_req(REQ_DELETE, 8'h00, 8'h00, 8'h00);
    send_req(REQ_MODIFY, 8'hFF, 8'hFF, 8'hFF);

    // Fill the table: zero interval, full-scale fields, a never-served task,
    // and a duplicate handle.
    send_req(REQ_CREATE, 8'hFF, 8'h00, 8'h01);
    send_req(REQ_CREATE, 8'h00, 8'h00, 8'hFF);
    send_req(REQ_CREATE, 8'hAA, 8'h03, 8'h80);
    pause_sender(3);
    send_req(REQ_CREATE, 8'h55, 8'hFF, 8'h00);
    send_req(REQ_CREATE, 8'hAA, 8'h01, 8'h01);
    send_req(REQ_CREATE, 8'h01, 8'h02, 8'h02);
    send_req(REQ_CREATE, 8'h80, 8'hC8, 8'h7F);
    send_req(REQ_CREATE, 8'h7F, 8'h00, 8'h01);
    // One past full.
    send_req(REQ_CREATE, 8'h33, 8'h05, 8'h05);

    send_req(REQ_TICK, 8'h00, 8'h00, 8'h00);
    send_req(REQ_TICK, 8'hFF, 8'hFF, 8'hFF);
    // Lower an interval below the running count; the count is kept.
    send_req(REQ_MODIFY, 8'h80, 8'h01, 8'hFF);
    send_req(REQ_TICK, 8'h00, 8'h00, 8'h00);

    // Delete the first of two duplicates, then the head, then the tail.
    send_req(REQ_DELETE, 8'hAA, 8'h00, 8'h00);
    pause_sender(5);
    send_req(REQ_DELETE, 8'hFF, 8'h00, 8'h00);
    send_req(REQ_DELETE, 8'h7F, 8'h00, 8'h00);
    // Wake the never-served task and make everything fire at once.
    send_req(REQ_MODIFY, 8'h55, 8'h00, 8'h03);
    send_req(REQ_MODIFY, 8'hAA, 8'h00, 8'h01);
    send_req(REQ_MODIFY, 8'h01, 8'h00, 8'h02);
    send_req(REQ_TICK, 8'h00, 8'h00, 8'h00);
    wait_drained();

    // Random part: mostly pooled handles so delete and modify hit real
    // entries; phases alternate between filling and emptying the table.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if ((sent / 60) % 2 == 0) begin
          w_create = 35; w_delete = 10; w_modify = 15;
        end else begin
          w_create = 15; w_delete = 30; w_modify = 15;
        end
        r = $urandom_range(0, 99);
        if (r < w_create) begin
          req = REQ_CREATE;
        end else if (r < w_create + w_delete) begin
          req = REQ_DELETE;
        end else if (r < w_create + w_delete + w_modify) begin
          req = REQ_MODIFY;
        end else begin
          req = REQ_TICK;
        end

        if ($urandom_range(0, 99) < 85) h = handle_pool[$urandom_range(0, 5)];
        else h = 8'($urandom_range(0, 255));

        r = $urandom_range(0, 9);
        if (r < 7)      per = 8'($urandom_range(0, 4));
        else if (r < 9) per = 8'($urandom_range(5, 20));
        else            per = 8'($urandom_range(0, 255));

        r = $urandom_range(0, 9);
        if (r == 0)     pri = 8'd0;
        else if (r < 8) pri = 8'($urandom_range(1, 4));
        else            pri = 8'($urandom_range(0, 255));

        send_req(req, h, per, pri);
        sent++;
        // Pause once mid-run until the block has answered everything.
        if (sent == RANDOM_ITEMS / 2) wait_drained();
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      pause_sender(gap);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && rows_waiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/ptts_pkg.sv
rtl/core/ptts_table_ram.sv
rtl/core/ptts_fire_buf.sv
rtl/core/periodic_task_table_scheduler.sv
tb/ptts_result_check.sv
tb/tb_periodic_task_table_scheduler.sv
